@@ rtl/rmgt_pkg.sv @@
// package: command and status codes, sizes and fixed-point helpers for the gradient tape
`default_nettype none
package rmgt_pkg;
    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;
    localparam int FRAC_BITS = 16;
    localparam int NODE_W = 8;
    localparam int EDGE_W = 11;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_NEW_NODE = 3'd0,
        CMD_ADD_EDGE = 3'd1,
        CMD_SCALE    = 3'd2,
        CMD_BACKWARD = 3'd3,
        CMD_READ_ADJ = 3'd4,
        CMD_READ_HD  = 3'd5,
        CMD_CLEAR    = 3'd6,
        CMD_BAD      = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NODE_FULL = 2'd1,
        ST_EDGE_FULL = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ADD_RD, S_SC_RD, S_SC_MUL, S_SC_WR,
        S_ZERO, S_NODE_RD, S_NODE_WAIT, S_EDGE_RD, S_EDGE_MUL, S_CH_RD,
        S_CH_WR, S_READ_WAIT, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/rmgt_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module rmgt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ rtl/reverse_mode_gradient_tape.sv @@
// top level: gradient tape sequencer over node and edge memories
//
// channel  dir  tdata fields (low bit up)                       handshake
// s_axis   in   cmd, from_node, to_node, weight, scale, start_edge  tvalid/tready
// m_axis   out  status, new_node, head_edge, adjoint_value,
//               nodes_used, edges_used                          tvalid/tready
//
// scale chain reads, scales and writes back each edge weight along the chain, one memory port per table
// backward zeroes all adjoints, seeds the start node with one, then walks the nodes downward and each node's edges
// synchronous active-low reset clears the sequencer and both counters, memories are not cleared
// a new item is taken once the previous result has moved into the output register
`default_nettype none
module reverse_mode_gradient_tape
    import rmgt_pkg::*;
#(
    parameter int P_MAX_NODES = rmgt_pkg::MAX_NODES,
    parameter int P_MAX_EDGES = rmgt_pkg::MAX_EDGES,
    parameter int P_FRAC_BITS = rmgt_pkg::FRAC_BITS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], from_node[10:3], to_node[18:11], weight[50:19], scale[82:51],
    // start_edge[93:83], zero fill to 96
    input  wire  [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status[1:0], new_node[9:2], head_edge[20:10], adjoint_value[52:21],
    // nodes_used[61:53], edges_used[72:62], zero fill to 80
    output logic [79:0]  m_axis_tdata
);
    localparam int NA = $clog2(P_MAX_NODES);
    localparam int EA = $clog2(P_MAX_EDGES);
    localparam int NC = $clog2(P_MAX_NODES + 1);
    localparam int EC = $clog2(P_MAX_EDGES + 1);
    localparam logic signed [31:0] ONE = 32'sd1 <<< P_FRAC_BITS;

    t_state r_state, n_state;
    logic [NC-1:0] r_ncnt, n_ncnt;
    logic [EC-1:0] r_ecnt, n_ecnt;
    logic [2:0]  r_cmd, n_cmd;
    logic [7:0]  r_a, n_a, r_b, n_b;
    logic signed [31:0] r_w, n_w, r_sc, n_sc;
    logic signed [10:0] r_se, n_se;
    logic [NC-1:0] r_idx, n_idx;
    logic signed [10:0] r_cur, n_cur;
    logic signed [31:0] r_padj, n_padj, r_prod, n_prod;
    logic [7:0]  r_child, n_child;
    logic signed [10:0] r_next, n_next;
    logic        r_ovld, n_ovld;
    logic [1:0]  r_ost, n_ost;
    logic [7:0]  r_onn, n_onn;
    logic signed [10:0] r_ohd, n_ohd;
    logic signed [31:0] r_oadj, n_oadj;
    logic signed [63:0] r_mul, n_mul;
    logic [79:0] r_mdata, n_mdata;

    logic hd_we, adj_we, ec_we, ew_we, en_we;
    logic [NA-1:0] hd_addr, adj_addr;
    logic [EA-1:0] e_addr;
    logic [10:0] hd_wd, hd_rd, en_wd, en_rd;
    logic [31:0] adj_wd, adj_rd, ew_wd, ew_rd;
    logic [7:0]  ec_wd, ec_rd;

    rmgt_ram #(.WIDTH(11), .DEPTH(P_MAX_NODES)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_addr(hd_addr), .i_wdata(hd_wd), .o_rdata(hd_rd));
    rmgt_ram #(.WIDTH(32), .DEPTH(P_MAX_NODES)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_addr(adj_addr), .i_wdata(adj_wd), .o_rdata(adj_rd));
    rmgt_ram #(.WIDTH(8), .DEPTH(P_MAX_EDGES)) u_child (
        .i_clk(i_clk), .i_we(ec_we), .i_addr(e_addr), .i_wdata(ec_wd), .o_rdata(ec_rd));
    rmgt_ram #(.WIDTH(32), .DEPTH(P_MAX_EDGES)) u_wt (
        .i_clk(i_clk), .i_we(ew_we), .i_addr(e_addr), .i_wdata(ew_wd), .o_rdata(ew_rd));
    rmgt_ram #(.WIDTH(11), .DEPTH(P_MAX_EDGES)) u_next (
        .i_clk(i_clk), .i_we(en_we), .i_addr(e_addr), .i_wdata(en_wd), .o_rdata(en_rd));

    logic out_free;
    assign out_free = !r_ovld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = r_mdata;

    // floor-shift product and saturate
    function automatic logic signed [31:0] fxq(input logic signed [63:0] p);
        return sat32(p >>> P_FRAC_BITS);
    endfunction

    always_comb begin
        logic signed [32:0] s;
        n_state = r_state; n_ncnt = r_ncnt; n_ecnt = r_ecnt;
        n_cmd = r_cmd; n_a = r_a; n_b = r_b; n_w = r_w; n_sc = r_sc; n_se = r_se;
        n_idx = r_idx; n_cur = r_cur; n_padj = r_padj; n_prod = r_prod;
        n_child = r_child; n_next = r_next; n_mul = r_mul;
        n_ovld = r_ovld; n_ost = r_ost; n_onn = r_onn; n_ohd = r_ohd; n_oadj = r_oadj;
        n_mdata = r_mdata;
        hd_we = 1'b0; adj_we = 1'b0; ec_we = 1'b0; ew_we = 1'b0; en_we = 1'b0;
        hd_addr = NA'(r_a); adj_addr = NA'(r_a); e_addr = EA'(r_cur);
        hd_wd = 11'h7ff; adj_wd = '0; ec_wd = r_b; ew_wd = r_w; en_wd = hd_rd;
        s = '0;
        if (r_ovld && m_axis_tready) n_ovld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd = s_axis_tdata[2:0]; n_a = s_axis_tdata[10:3];
                    n_b = s_axis_tdata[18:11]; n_w = s_axis_tdata[50:19];
                    n_sc = s_axis_tdata[82:51]; n_se = s_axis_tdata[93:83];
                    n_ost = ST_OK; n_onn = '0; n_ohd = 11'h7ff; n_oadj = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                unique case (t_cmd'(r_cmd))
                    CMD_NEW_NODE: begin
                        if (r_ncnt >= NC'(P_MAX_NODES)) n_ost = ST_NODE_FULL;
                        else begin
                            hd_addr = NA'(r_ncnt); adj_addr = NA'(r_ncnt);
                            hd_we = 1'b1; adj_we = 1'b1;
                            n_onn = 8'(r_ncnt); n_ncnt = r_ncnt + 1'b1;
                        end
                    end
                    CMD_ADD_EDGE: begin
                        if ({1'b0, r_a} >= 9'(r_ncnt) || {1'b0, r_b} >= 9'(r_ncnt))
                            n_ost = ST_RANGE;
                        else if (r_ecnt >= EC'(P_MAX_EDGES)) n_ost = ST_EDGE_FULL;
                        else n_state = S_ADD_RD;
                    end
                    CMD_SCALE: begin
                        if (r_sc == ONE || r_se == -11'sd1) n_state = S_OUT;
                        else if (r_se[10] || {1'b0, r_se} >= {1'b0, 11'(r_ecnt)})
                            n_ost = ST_RANGE;
                        else begin
                            n_cur = r_se; n_state = S_SC_RD;
                        end
                    end
                    CMD_BACKWARD: begin
                        if ({1'b0, r_a} >= 9'(r_ncnt)) n_ost = ST_RANGE;
                        else begin
                            n_idx = '0; n_state = S_ZERO;
                        end
                    end
                    CMD_READ_ADJ, CMD_READ_HD: begin
                        if ({1'b0, r_a} >= 9'(r_ncnt)) n_ost = ST_RANGE;
                        else n_state = S_READ_WAIT;
                    end
                    CMD_CLEAR: begin
                        n_ncnt = '0; n_ecnt = '0;
                    end
                    default: n_ost = ST_RANGE;
                endcase
            end
            S_READ_WAIT: begin
                if (r_cmd == CMD_READ_ADJ) n_oadj = adj_rd;
                else n_ohd = hd_rd;
                n_state = S_OUT;
            end
            S_ADD_RD: begin
                e_addr = EA'(r_ecnt);
                ec_we = 1'b1; ew_we = 1'b1; en_we = 1'b1; en_wd = hd_rd;
                hd_we = 1'b1; hd_wd = 11'(r_ecnt);
                n_ecnt = r_ecnt + 1'b1;
                n_state = S_OUT;
            end
            S_SC_RD: n_state = S_SC_MUL;
            S_SC_MUL: begin
                n_mul = 64'(signed'(ew_rd)) * 64'(r_sc);
                n_next = en_rd;
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                ew_we = 1'b1; ew_wd = fxq(r_mul);
                n_cur = r_next;
                n_state = (!r_next[10] && {1'b0, r_next} < {1'b0, 11'(r_ecnt)})
                          ? S_SC_RD : S_OUT;
            end
            S_ZERO: begin
                adj_addr = NA'(r_idx); adj_we = 1'b1;
                adj_wd = (NA'(r_idx) == NA'(r_a)) ? ONE : '0;
                n_idx = r_idx + 1'b1;
                if (r_idx + 1'b1 == r_ncnt) n_state = S_NODE_RD;
            end
            S_NODE_RD: begin
                if (r_idx == '0) n_state = S_OUT;
                else begin
                    hd_addr = NA'(r_idx - 1'b1); adj_addr = NA'(r_idx - 1'b1);
                    n_idx = r_idx - 1'b1;
                    n_state = S_NODE_WAIT;
                end
            end
            S_NODE_WAIT: begin
                n_cur = hd_rd; n_padj = adj_rd;
                n_state = (!hd_rd[10] && {1'b0, hd_rd} < {1'b0, 11'(r_ecnt)})
                          ? S_EDGE_RD : S_NODE_RD;
            end
            S_EDGE_RD: n_state = S_EDGE_MUL;
            S_EDGE_MUL: begin
                n_mul = 64'(signed'(ew_rd)) * 64'(r_padj);
                n_child = ec_rd; n_next = en_rd;
                n_state = S_CH_RD;
            end
            S_CH_RD: begin
                n_prod = fxq(r_mul);
                adj_addr = NA'(r_child);
                if ({1'b0, r_child} < 9'(r_ncnt)) n_state = S_CH_WR;
                else begin
                    n_cur = r_next;
                    n_state = (!r_next[10] && {1'b0, r_next} < {1'b0, 11'(r_ecnt)})
                              ? S_EDGE_RD : S_NODE_RD;
                end
            end
            S_CH_WR: begin
                adj_addr = NA'(r_child); adj_we = 1'b1;
                s = 33'(signed'(adj_rd)) + 33'(r_prod);
                adj_wd = sat32(64'(s));
                // self edge updates the parent adjoint used by later edges
                if (NC'(r_child) == r_idx) n_padj = sat32(64'(s));
                n_cur = r_next;
                n_state = (!r_next[10] && {1'b0, r_next} < {1'b0, 11'(r_ecnt)})
                          ? S_EDGE_RD : S_NODE_RD;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovld = 1'b1; n_state = S_IDLE;
                    n_mdata = {7'd0, 11'(r_ecnt), 9'(r_ncnt), r_oadj, r_ohd, r_onn, r_ost};
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ncnt <= '0; r_ecnt <= '0; r_ovld <= 1'b0;
        end else begin
            r_state <= n_state; r_ncnt <= n_ncnt; r_ecnt <= n_ecnt; r_ovld <= n_ovld;
        end
        r_cmd <= n_cmd; r_a <= n_a; r_b <= n_b; r_w <= n_w; r_sc <= n_sc; r_se <= n_se;
        r_idx <= n_idx; r_cur <= n_cur; r_padj <= n_padj; r_prod <= n_prod;
        r_child <= n_child; r_next <= n_next; r_mul <= n_mul;
        r_ost <= n_ost; r_onn <= n_onn; r_ohd <= n_ohd; r_oadj <= n_oadj;
        r_mdata <= n_mdata;
    end

    a_cnt_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= NC'(P_MAX_NODES)) else $error("node count overflow");
    a_cnt_e: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= EC'(P_MAX_EDGES)) else $error("edge count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("double accept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready) |=> r_ovld) else $error("result dropped");
endmodule
`default_nettype wire

@@ tb/reverse_mode_gradient_tape_test.sv @@
// testbench: random and directed command streams against a scoreboard model of the gradient tape
`timescale 1ns / 1ps
module reverse_mode_gradient_tape_test;
    import rmgt_pkg::*;

    localparam int WATCH_LIMIT = 60000;
    localparam int RANDOM_ITEMS = 1350;
    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

    typedef struct {
        t_cmd cmd;
        logic [7:0] from_n;
        logic [7:0] to_n;
        logic signed [31:0] weight;
        logic signed [31:0] scale;
        logic signed [10:0] start_e;
    } t_tape_cmd;

    typedef struct {
        t_status status;
        logic [7:0] new_node;
        logic signed [10:0] head;
        logic signed [31:0] adj;
        logic [8:0] nodes;
        logic [10:0] edges;
    } t_tape_resp;

    class t_tape_scoreboard;
        int head_t[MAX_NODES];
        logic [7:0] child_t[MAX_EDGES];
        logic signed [31:0] wt_t[MAX_EDGES];
        int next_t[MAX_EDGES];
        logic signed [31:0] adj_t[MAX_NODES];
        int node_cnt;
        int edge_cnt;
        int errors;
        t_tape_resp pending_q[$];

        function logic signed [31:0] sat(input logic signed [63:0] v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [31:0] fx_mul(input logic signed [31:0] x,
                                            input logic signed [31:0] y);
            logic signed [63:0] p;
            p = 64'(x) * 64'(y);
            return sat(p >>> FRAC_BITS);
        endfunction

        function logic signed [31:0] fx_add(input logic signed [31:0] x,
                                            input logic signed [31:0] y);
            return sat(64'(x) + 64'(y));
        endfunction

        function void note(input t_tape_cmd c);
            t_tape_resp r;
            int cur;
            int se;
            int p;
            r.status = ST_OK;
            r.new_node = 0;
            r.head = -11'sd1;
            r.adj = 0;
            se = int'(c.start_e);
            case (c.cmd)
                CMD_NEW_NODE: begin
                    if (node_cnt >= MAX_NODES) begin
                        r.status = ST_NODE_FULL;
                    end else begin
                        head_t[node_cnt] = -1;
                        adj_t[node_cnt] = 0;
                        r.new_node = node_cnt[7:0];
                        node_cnt++;
                    end
                end
                CMD_ADD_EDGE: begin
                    if (c.from_n >= node_cnt || c.to_n >= node_cnt) begin
                        r.status = ST_RANGE;
                    end else if (edge_cnt >= MAX_EDGES) begin
                        r.status = ST_EDGE_FULL;
                    end else begin
                        child_t[edge_cnt] = c.to_n;
                        wt_t[edge_cnt] = c.weight;
                        next_t[edge_cnt] = head_t[c.from_n];
                        head_t[c.from_n] = edge_cnt;
                        edge_cnt++;
                    end
                end
                CMD_SCALE: begin
                    if (!(c.scale == FX_ONE || se == -1)) begin
                        if (se < 0 || se >= edge_cnt) begin
                            r.status = ST_RANGE;
                        end else begin
                            cur = se;
                            while (cur >= 0 && cur < edge_cnt) begin
                                wt_t[cur] = fx_mul(wt_t[cur], c.scale);
                                cur = next_t[cur];
                            end
                        end
                    end
                end
                CMD_BACKWARD: begin
                    if (c.from_n >= node_cnt) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (int i = 0; i < node_cnt; i++) adj_t[i] = 0;
                        adj_t[c.from_n] = FX_ONE;
                        for (p = node_cnt - 1; p >= 0; p--) begin
                            cur = head_t[p];
                            while (cur >= 0 && cur < edge_cnt) begin
                                if (child_t[cur] < node_cnt)
                                    adj_t[child_t[cur]] = fx_add(adj_t[child_t[cur]],
                                        fx_mul(wt_t[cur], adj_t[p]));
                                cur = next_t[cur];
                            end
                        end
                    end
                end
                CMD_READ_ADJ: begin
                    if (c.from_n >= node_cnt) r.status = ST_RANGE;
                    else r.adj = adj_t[c.from_n];
                end
                CMD_READ_HD: begin
                    if (c.from_n >= node_cnt) r.status = ST_RANGE;
                    else r.head = head_t[c.from_n][10:0];
                end
                CMD_CLEAR: begin
                    node_cnt = 0;
                    edge_cnt = 0;
                end
                default: r.status = ST_RANGE;
            endcase
            r.nodes = node_cnt[8:0];
            r.edges = edge_cnt[10:0];
            pending_q = {pending_q, r};
        endfunction

        task report(input string field, input longint got, input longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
            errors++;
        endtask

        task check(input t_tape_resp g);
            t_tape_resp e;
            if (pending_q.size() == 0) begin
                report("unexpected item", 1, 0);
            end else begin
                e = pending_q.pop_front();
                if (g.status != e.status) report("status", g.status, e.status);
                if (g.new_node != e.new_node) report("new_node", g.new_node, e.new_node);
                if (g.head != e.head) report("head_edge", g.head, e.head);
                if (g.adj != e.adj) report("adjoint_value", g.adj, e.adj);
                if (g.nodes != e.nodes) report("nodes_used", g.nodes, e.nodes);
                if (g.edges != e.edges) report("edges_used", g.edges, e.edges);
            end
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    wire s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    wire m_axis_tvalid;
    logic m_axis_tready = 0;
    wire [79:0] m_axis_tdata;

    t_tape_scoreboard sb = new();
    int hold_len = 0;
    bit no_idle = 0;
    int quiet_cycles = 0;

    reverse_mode_gradient_tape dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // cmd, from_node, to_node, weight, scale, start_edge
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // status, new_node, head_edge, adjoint_value, nodes_used, edges_used
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task send_cmd(input t_tape_cmd c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {2'b00, c.start_e, c.scale, c.weight, c.to_n, c.from_n, c.cmd};
        s_axis_tvalid = 1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(c);
        @(negedge i_clk);
    endtask

    task wait_drain();
        s_axis_tvalid = 0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    function t_tape_cmd mk(input t_cmd cmd, input int a, input int b, input int w,
                           input int sc, input int se);
        t_tape_cmd c;
        c.cmd = cmd;
        c.from_n = a[7:0];
        c.to_n = b[7:0];
        c.weight = w;
        c.scale = sc;
        c.start_e = se[10:0];
        return c;
    endfunction

    function int pick_node();
        if (sb.node_cnt > 0 && $urandom_range(0, 99) < 88)
            return $urandom_range(0, sb.node_cnt - 1);
        return $urandom_range(0, 255);
    endfunction

    function int pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return FX_ONE;
            default: return int'($urandom_range(0, 4 << FRAC_BITS)) - (2 << FRAC_BITS);
        endcase
    endfunction

    function t_tape_cmd rand_cmd(input bit filling);
        t_tape_cmd c;
        int k;
        int se;
        c = mk(CMD_READ_HD, pick_node(), pick_node(), pick_value(), pick_value(), 0);
        k = $urandom_range(0, 99);
        if (!filling && sb.node_cnt > 16 && k < 20) k = 99;
        if (k < 22) c.cmd = CMD_NEW_NODE;
        else if (k < 52) c.cmd = CMD_ADD_EDGE;
        else if (k < 62) c.cmd = CMD_SCALE;
        else if (k < 70) c.cmd = CMD_BACKWARD;
        else if (k < 83) c.cmd = CMD_READ_ADJ;
        else if (k < 94) c.cmd = CMD_READ_HD;
        else if (k < 97) c.cmd = CMD_BAD;
        else c.cmd = CMD_CLEAR;
        case ($urandom_range(0, 9))
            0: se = -1;
            1: se = $urandom_range(0, 2047);
            default: se = sb.edge_cnt > 0 ? $urandom_range(0, sb.edge_cnt - 1) : -1;
        endcase
        c.start_e = se[10:0];
        if (c.cmd == CMD_BAD && $urandom_range(0, 1)) begin
            c.from_n = 8'($urandom);
            c.start_e = 11'($urandom);
        end
        return c;
    endfunction

    initial begin
        t_tape_resp g;
        int hold;
        forever begin
            if (hold_len > 0) begin
                hold = hold_len;
                hold_len = 0;
                m_axis_tready = 0;
                repeat (hold) @(negedge i_clk);
            end else if (!no_idle) begin
                hold = $urandom_range(0, 3);
                if (hold > 0) begin
                    m_axis_tready = 0;
                    repeat (hold) @(negedge i_clk);
                end
            end
            m_axis_tready = 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            g.status = t_status'(m_axis_tdata[1:0]);
            g.new_node = m_axis_tdata[9:2];
            g.head = m_axis_tdata[20:10];
            g.adj = m_axis_tdata[52:21];
            g.nodes = m_axis_tdata[61:53];
            g.edges = m_axis_tdata[72:62];
            sb.check(g);
            @(negedge i_clk);
        end
    end

    initial begin
        int sent;
        int fill_at;
        int tail;
        sb.node_cnt = 0;
        sb.edge_cnt = 0;
        sb.errors = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: range errors, extreme weights, unit scale, empty and bad chains
        send_cmd(mk(CMD_READ_ADJ, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_NEW_NODE, 255, 255, -1, -1, -1));
        send_cmd(mk(CMD_NEW_NODE, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_NEW_NODE, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_ADD_EDGE, 0, 1, 32'h7fffffff, 0, 0));
        send_cmd(mk(CMD_ADD_EDGE, 1, 2, 32'h80000000, 0, 0));
        send_cmd(mk(CMD_ADD_EDGE, 0, 2, FX_ONE, 0, 0));
        send_cmd(mk(CMD_ADD_EDGE, 255, 0, 0, 0, 0));
        send_cmd(mk(CMD_ADD_EDGE, 0, 255, 0, 0, 0));
        send_cmd(mk(CMD_READ_HD, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_READ_HD, 5, 0, 0, 0, 0));
        send_cmd(mk(CMD_SCALE, 0, 0, 0, 32'h80000000, -1));
        send_cmd(mk(CMD_SCALE, 0, 0, 0, FX_ONE, 1000));
        send_cmd(mk(CMD_SCALE, 0, 0, 0, 3 << FRAC_BITS, 1000));
        send_cmd(mk(CMD_SCALE, 0, 0, 0, 3 << FRAC_BITS, -1024));
        send_cmd(mk(CMD_SCALE, 0, 0, 0, -FX_ONE, 2));
        send_cmd(mk(CMD_BACKWARD, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_READ_ADJ, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_READ_ADJ, 1, 0, 0, 0, 0));
        send_cmd(mk(CMD_READ_ADJ, 2, 0, 0, 0, 0));
        send_cmd(mk(CMD_BACKWARD, 9, 0, 0, 0, 0));
        send_cmd(mk(CMD_BAD, 255, 255, -1, -1, -1));
        send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(mk(CMD_READ_HD, 0, 0, 0, 0, 0));

        wait_drain();
        fill_at = $urandom_range(20, 30);
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == fill_at) begin
                // full tables: node full, edge full, a scale chain, then a backward over everything and reads
                send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
                hold_len = 300;
                for (int i = 0; i <= MAX_NODES; i++)
                    send_cmd(mk(CMD_NEW_NODE, 0, 0, 0, 0, 0));
                for (int i = 0; i <= MAX_EDGES; i++)
                    send_cmd(mk(CMD_ADD_EDGE, $urandom_range(0, 255), $urandom_range(0, 255),
                                pick_value(), 0, 0));
                send_cmd(mk(CMD_SCALE, 0, 0, 0, pick_value(), $urandom_range(0, 1023)));
                send_cmd(mk(CMD_BACKWARD, $urandom_range(0, 255), 0, 0, 0, 0));
                for (int i = 0; i < 4; i++)
                    send_cmd(mk(CMD_READ_ADJ, $urandom_range(0, 255), 0, 0, 0, 0));
                send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
                wait_drain();
                sent += 1290;
            end
            if (sent % 30 == 5) no_idle = 1;
            if (sent % 30 == 20) no_idle = 0;
            send_cmd(rand_cmd(0));
            sent++;
        end
        wait_drain();

        tail = 0;
        while (tail < 100) begin
            @(negedge i_clk);
            tail++;
        end
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/rmgt_pkg.sv
rtl/rmgt_ram.sv
rtl/reverse_mode_gradient_tape.sv
tb/reverse_mode_gradient_tape_test.sv
